// File: hdl/sic_pkg.sv
package sic_pkg;

  // fixed-point constants of the scattering datapath
  localparam logic [27:0] KR = 28'((64'd3 << 32) * 64'd100000 / (64'd16 * 64'd314159));
  localparam logic [20:0] KM = 21'((64'd1 << 24) * 64'd100000 / (64'd4 * 64'd314159));
  localparam logic [14:0] G_CAP = 15'd32440;
  localparam logic [47:0] OUT_MAX = 48'hFFFF_FFFF_FFFF;

  localparam int D46_W = 48;
  localparam int ROOT_W = 24;
  localparam int SQ_REM_W = 26;
  localparam int DD_W = 35;
  localparam int NUM_W = 51;
  localparam int DVD_W = 64;
  localparam int QUO_W = 43;
  localparam int PR_W = 29;

  typedef enum logic [2:0] {
    REG_SUN_DIR_X = 3'd0,
    REG_SUN_DIR_Y = 3'd1,
    REG_SUN_DIR_Z = 3'd2,
    REG_RED_RAYLEIGH = 3'd3,
    REG_GREEN_RAYLEIGH = 3'd4,
    REG_BLUE_RAYLEIGH = 3'd5,
    REG_MIE_SCALED = 3'd6,
    REG_MIE_ASYMMETRY = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic signed [15:0] view_x;
    logic signed [15:0] view_y;
    logic signed [15:0] view_z;
  } view_t;

  typedef struct packed {
    logic [47:0] inscatter_red;
    logic [47:0] inscatter_green;
    logic [47:0] inscatter_blue;
  } result_t;

  typedef struct packed {
    logic signed [15:0] sun_dir_x;
    logic signed [15:0] sun_dir_y;
    logic signed [15:0] sun_dir_z;
    logic [31:0] red_rayleigh_scaled;
    logic [31:0] green_rayleigh_scaled;
    logic [31:0] blue_rayleigh_scaled;
    logic [31:0] mie_scaled;
    logic [14:0] mie_asymmetry;
  } cfg_t;

  // values riding along the iterative units
  typedef struct packed {
    logic [PR_W-1:0] pr;
    logic [DD_W-1:0] dd;
    logic [NUM_W-1:0] num;
  } side_t;

endpackage

// File: hdl/sic_front.sv
module sic_front (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  sic_pkg::cfg_t cfg,
  input  logic in_valid,
  input  sic_pkg::view_t in_data,
  output logic out_valid,
  output logic [sic_pkg::D46_W-1:0] d46,
  output sic_pkg::side_t side
);

  // stage 1: component products, capped g
  logic v1;
  logic signed [31:0] px, py, pz;
  logic [14:0] g1;
  logic [29:0] g2_1;
  logic [14:0] g_capped;

  assign g_capped = (cfg.mie_asymmetry > sic_pkg::G_CAP) ? sic_pkg::G_CAP : cfg.mie_asymmetry;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      px <= in_data.view_x * cfg.sun_dir_x;
      py <= in_data.view_y * cfg.sun_dir_y;
      pz <= in_data.view_z * cfg.sun_dir_z;
      g1 <= g_capped;
      g2_1 <= g_capped * g_capped;
    end
  end

  // stage 2: dot product, clamp to [-1,1]
  localparam logic signed [33:0] ONE30 = 34'sd1073741824;
  logic v2;
  logic signed [31:0] c2;
  logic [14:0] g_2;
  logic [29:0] g2_2;
  logic signed [33:0] dot;

  assign dot = 34'(px) + 34'(py) + 34'(pz);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      if (dot > ONE30) begin
        c2 <= 32'(ONE30);
      end else if (dot < -ONE30) begin
        c2 <= 32'(-ONE30);
      end else begin
        c2 <= 32'(dot);
      end
      g_2 <= g1;
      g2_2 <= g2_1;
    end
  end

  // stage 3: cos squared, g*cos, phase numerator
  logic v3;
  logic [30:0] csq3;
  logic signed [47:0] gc3;
  logic [29:0] g2_3;
  logic [sic_pkg::NUM_W-1:0] num3;
  logic [30:0] mag;
  logic [61:0] magsq;
  logic [51:0] num_full;

  assign mag = c2[31] ? 31'(-c2) : 31'(c2);
  assign magsq = mag * mag;
  assign num_full = (31'h4000_0000 - 31'(g2_2)) * sic_pkg::KM;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      csq3 <= magsq[60:30];
      gc3 <= $signed({1'b0, g_2}) * c2;
      g2_3 <= g2_2;
      num3 <= num_full[sic_pkg::NUM_W-1:0];
    end
  end

  // stage 4: rayleigh phase and mie denominator
  logic [59:0] pr_full;
  logic signed [48:0] d45;

  assign pr_full = sic_pkg::KR * (32'h4000_0000 + 32'(csq3));
  assign d45 = 49'sh2000_0000_0000 + $signed({4'b0, g2_3, 15'b0})
             - (49'(gc3) <<< 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      d46 <= {d45[46:0], 1'b0};
      side.pr <= pr_full[58:30];
      side.dd <= d45[46:12];
      side.num <= num3;
    end
  end

endmodule

// File: hdl/sic_isqrt.sv
module sic_isqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [sic_pkg::D46_W-1:0] value,
  input  sic_pkg::side_t in_side,
  output logic out_valid,
  output logic [sic_pkg::ROOT_W-1:0] root,
  output sic_pkg::side_t out_side
);

  localparam int N = sic_pkg::ROOT_W;
  localparam int RW = sic_pkg::SQ_REM_W;
  localparam int VW = sic_pkg::D46_W;

  logic vld [0:N];
  logic [RW-1:0] rem [0:N];
  logic [N-1:0] rt [0:N];
  logic [VW-1:0] val [0:N];
  sic_pkg::side_t sd [0:N];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0] = '0;
  assign val[0] = value;
  assign sd[0] = in_side;

  // one root bit per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [RW+1:0] cur;
    logic [RW+1:0] trial;
    assign cur = {rem[k], val[k][VW-1:VW-2]};
    assign trial = {2'b0, rt[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        if (cur >= trial) begin
          rem[k+1] <= RW'(cur - trial);
          rt[k+1] <= {rt[k][N-2:0], 1'b1};
        end else begin
          rem[k+1] <= RW'(cur);
          rt[k+1] <= {rt[k][N-2:0], 1'b0};
        end
        val[k+1] <= {val[k][VW-3:0], 2'b0};
        sd[k+1] <= sd[k];
      end
    end
  end

  assign out_valid = vld[N];
  assign root = rt[N];
  assign out_side = sd[N];

endmodule

// File: hdl/sic_div.sv
module sic_div (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [sic_pkg::DVD_W-1:0] dividend,
  input  logic [sic_pkg::DD_W-1:0] divisor,
  input  sic_pkg::side_t in_side,
  output logic out_valid,
  output logic [sic_pkg::QUO_W-1:0] quot,
  output sic_pkg::side_t out_side
);

  localparam int N = sic_pkg::QUO_W;
  localparam int DW = sic_pkg::DD_W;
  localparam int HW = sic_pkg::DVD_W - sic_pkg::QUO_W;

  logic vld [0:N];
  logic [DW-1:0] rem [0:N];
  logic [N-1:0] low [0:N];
  logic [N-1:0] qt [0:N];
  logic [DW-1:0] dvs [0:N];
  sic_pkg::side_t sd [0:N];

  // the quotient is known to fit, so the upper dividend bits start below the divisor
  assign vld[0] = in_valid;
  assign rem[0] = DW'(dividend[sic_pkg::DVD_W-1:N]);
  assign low[0] = dividend[N-1:0];
  assign qt[0] = '0;
  assign dvs[0] = divisor;
  assign sd[0] = in_side;

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [DW:0] t;
    assign t = {rem[k], low[k][N-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
      if (en) begin
        if (t >= {1'b0, dvs[k]}) begin
          rem[k+1] <= DW'(t - {1'b0, dvs[k]});
          qt[k+1] <= {qt[k][N-2:0], 1'b1};
        end else begin
          rem[k+1] <= DW'(t);
          qt[k+1] <= {qt[k][N-2:0], 1'b0};
        end
        low[k+1] <= {low[k][N-2:0], 1'b0};
        dvs[k+1] <= dvs[k];
        sd[k+1] <= sd[k];
      end
    end
  end

  logic unused_hw;
  assign unused_hw = (HW > 0);

  assign out_valid = vld[N] & unused_hw;
  assign quot = qt[N];
  assign out_side = sd[N];

endmodule

// File: hdl/sic_back.sv
module sic_back (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  sic_pkg::cfg_t cfg,
  input  logic in_valid,
  input  logic [sic_pkg::QUO_W-1:0] pm,
  input  logic [sic_pkg::PR_W-1:0] pr,
  output logic out_valid,
  output sic_pkg::result_t out_data
);

  // stage 1: coefficient products
  logic v1;
  logic [60:0] rr, rg, rb;
  logic [63:0] ml;
  logic [42:0] mh;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      rr <= cfg.red_rayleigh_scaled * pr;
      rg <= cfg.green_rayleigh_scaled * pr;
      rb <= cfg.blue_rayleigh_scaled * pr;
      ml <= cfg.mie_scaled * pm[31:0];
      mh <= cfg.mie_scaled * pm[42:32];
    end
  end

  // stage 2: mie term, upper bits of the rayleigh products
  logic v2;
  logic [28:0] tr, tg, tb;
  logic [43:0] mie_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      tr <= rr[60:32];
      tg <= rg[60:32];
      tb <= rb[60:32];
      mie_term <= 44'(mh) + 44'(ml[63:32]);
    end
  end

  // stage 3: channel sums with saturation, output word
  logic [48:0] sr, sg, sb;
  assign sr = 49'(tr) + 49'(mie_term);
  assign sg = 49'(tg) + 49'(mie_term);
  assign sb = 49'(tb) + 49'(mie_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v2;
    end
    if (en) begin
      out_data.inscatter_red <= sr[48] ? sic_pkg::OUT_MAX : sr[47:0];
      out_data.inscatter_green <= sg[48] ? sic_pkg::OUT_MAX : sg[47:0];
      out_data.inscatter_blue <= sb[48] ? sic_pkg::OUT_MAX : sb[47:0];
    end
  end

endmodule

// File: hdl/sky_inscatter_color.sv
// throughput: one word per cycle unless the output stalls; the 24-stage
//   square root and the two 43-stage dividers are fully pipelined, one bit per stage
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// reset: synchronous, clears all valid bits and loads register defaults
module sky_inscatter_color (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sic_pkg::view_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output sic_pkg::result_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [31:0] cfg_data
);

  // configuration registers, always writable
  sic_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sun_dir_x <= 16'sd0;
      cfg.sun_dir_y <= 16'sd32767;
      cfg.sun_dir_z <= 16'sd0;
      cfg.red_rayleigh_scaled <= '0;
      cfg.green_rayleigh_scaled <= '0;
      cfg.blue_rayleigh_scaled <= '0;
      cfg.mie_scaled <= '0;
      cfg.mie_asymmetry <= 15'd24904;
    end else if (cfg_valid) begin
      unique case (sic_pkg::reg_index_t'(cfg_index))
        sic_pkg::REG_SUN_DIR_X: cfg.sun_dir_x <= cfg_data[15:0];
        sic_pkg::REG_SUN_DIR_Y: cfg.sun_dir_y <= cfg_data[15:0];
        sic_pkg::REG_SUN_DIR_Z: cfg.sun_dir_z <= cfg_data[15:0];
        sic_pkg::REG_RED_RAYLEIGH: cfg.red_rayleigh_scaled <= cfg_data;
        sic_pkg::REG_GREEN_RAYLEIGH: cfg.green_rayleigh_scaled <= cfg_data;
        sic_pkg::REG_BLUE_RAYLEIGH: cfg.blue_rayleigh_scaled <= cfg_data;
        sic_pkg::REG_MIE_SCALED: cfg.mie_scaled <= cfg_data;
        sic_pkg::REG_MIE_ASYMMETRY: cfg.mie_asymmetry <= cfg_data[14:0];
      endcase
    end
  end

  // global advance: the last stage is the output register
  logic en;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  // front end: dot, clamp, rayleigh phase, mie denominator (4 stages)
  logic fr_valid;
  logic [sic_pkg::D46_W-1:0] fr_d46;
  sic_pkg::side_t fr_side;

  sic_front u_front (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(in_valid), .in_data(in_data),
    .out_valid(fr_valid), .d46(fr_d46), .side(fr_side)
  );

  // square root of the doubled denominator term
  logic sq_valid;
  logic [sic_pkg::ROOT_W-1:0] sq_root;
  sic_pkg::side_t sq_side;

  sic_isqrt u_isqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(fr_valid), .value(fr_d46), .in_side(fr_side),
    .out_valid(sq_valid), .root(sq_root), .out_side(sq_side)
  );

  // first divide: numerator over the root
  logic d1_valid;
  logic [sic_pkg::QUO_W-1:0] d1_quot;
  sic_pkg::side_t d1_side;

  sic_div u_div_root (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(sq_valid),
    .dividend({1'b0, sq_side.num, 12'b0}),
    .divisor(sic_pkg::DD_W'(sq_root)),
    .in_side(sq_side),
    .out_valid(d1_valid), .quot(d1_quot), .out_side(d1_side)
  );

  // second divide: over the scaled denominator, gives the mie phase
  logic d2_valid;
  logic [sic_pkg::QUO_W-1:0] d2_quot;
  sic_pkg::side_t d2_side;

  sic_div u_div_den (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(d1_valid),
    .dividend({d1_quot[41:0], 22'b0}),
    .divisor(d1_side.dd),
    .in_side(d1_side),
    .out_valid(d2_valid), .quot(d2_quot), .out_side(d2_side)
  );

  // back end: coefficient scaling and channel mix (3 stages)
  sic_back u_back (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(d2_valid), .pm(d2_quot), .pr(d2_side.pr),
    .out_valid(out_valid), .out_data(out_data)
  );

  // root of a positive denominator is never zero
  a_root_nonzero: assert property (@(posedge clk) disable iff (rst)
    sq_valid |-> sq_root != '0)
    else $error("square root is zero");

  // first quotient must fit before it is shifted into the second divide
  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    d1_valid |-> !d1_quot[sic_pkg::QUO_W-1])
    else $error("first quotient overflow");

  // with g capped the channel sums stay far below saturation
  a_no_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.inscatter_red[47:44] == 4'd0)
               && (out_data.inscatter_green[47:44] == 4'd0)
               && (out_data.inscatter_blue[47:44] == 4'd0))
    else $error("channel sum out of range");

  // a stalled pipeline holds the output word
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_data) && out_valid)
    else $error("output changed during stall");

endmodule
